// ===== rtl/drrip_pkg.sv =====
// ----------------------------------------------------------------------------
// drrip_pkg
// shared types, constants and default sizes of the drrip replacement block
// ----------------------------------------------------------------------------
package drrip_pkg;

    // default sizes
    localparam int P_NUM_SETS           = 2048;
    localparam int P_NUM_WAYS           = 16;
    localparam int P_NUM_CORES          = 4;
    localparam int P_LEADERS_PER_POLICY = 32;
    localparam int P_SELECTOR_BITS      = 10;
    localparam int P_BIMODAL_PERIOD     = 32;

    // request and response field widths
    localparam int CORE_ID_W   = 2;
    localparam int SET_INDEX_W = 11;
    localparam int WAY_INDEX_W = 4;

    // re-reference values
    localparam logic [1:0] RR_NEAR = 2'd0;
    localparam logic [1:0] RR_LONG = 2'd2;
    localparam logic [1:0] RR_MAX  = 2'd3;

    // action codes
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_VICTIM = 1'b1;

    // leader policy codes
    localparam logic POL_BRRIP = 1'b0;
    localparam logic POL_SRRIP = 1'b1;

    // leader draw generator: only seed bits [35:16] ever reach the candidate
    localparam int          LCG_SEED_W  = 36;
    localparam int          LCG_HALF_W  = 18;
    localparam int          CAND_LSB    = 16;
    localparam int          CAND_W      = 20;
    localparam logic [30:0] LCG_MULT    = 31'd1103515245;
    localparam logic [17:0] LCG_MULT_LO = LCG_MULT[17:0];
    localparam logic [13:0] LCG_INC     = 14'd12345;
    localparam logic [35:0] LCG_SEED0   = 36'd1;

    // draws per leader slot before the slot is left empty
    localparam int DRAW_W    = 16;
    localparam int MAX_DRAWS = 65536;

    typedef struct packed {
        logic                   action;
        logic [CORE_ID_W-1:0]   core_id;
        logic [SET_INDEX_W-1:0] set_index;
        logic [WAY_INDEX_W-1:0] way_index;
        logic                   hit;
        logic                   is_writeback;
    } t_req;

    typedef struct packed {
        logic                   victim_valid;
        logic [WAY_INDEX_W-1:0] victim_way;
    } t_rsp;

endpackage

// ===== rtl/drrip_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// drrip_cache_replacement
// dynamic rrip replacement with srrip / brrip set dueling per core
// ----------------------------------------------------------------------------
// Each set is one row of a synchronous ram: a 2-bit re-reference value per way
// plus the set's leader role (leader flag, policy, owning core). A request
// reads its row in the accept cycle and modifies and writes it back in the
// next; the next request is accepted in the cycle after the write, so a new
// request waits for the single read-modify-write of the set row. The
// response sits in an output register, and a stalled response holds the
// block in its write-back cycle.
// After reset o_req_ready stays low while the ram is swept: every row is
// written to all-distant with no role, then the leader sets are drawn
// one candidate at a time (lcg step, iterative reduction mod NUM_SETS,
// role probe), with a draw rejected when the set is already a leader.
// Policy selectors and the bimodal counter live in flops.
// ----------------------------------------------------------------------------
module drrip_cache_replacement #(
    parameter int NUM_SETS           = drrip_pkg::P_NUM_SETS,
    parameter int NUM_WAYS           = drrip_pkg::P_NUM_WAYS,
    parameter int NUM_CORES          = drrip_pkg::P_NUM_CORES,
    parameter int LEADERS_PER_POLICY = drrip_pkg::P_LEADERS_PER_POLICY,
    parameter int SELECTOR_BITS      = drrip_pkg::P_SELECTOR_BITS,
    parameter int BIMODAL_PERIOD     = drrip_pkg::P_BIMODAL_PERIOD
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  drrip_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output drrip_pkg::t_rsp o_rsp
);

    import drrip_pkg::*;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int ROLE_W    = CORE_W + 2;
    localparam int RR_W      = 2 * NUM_WAYS;
    localparam int ROW_W     = RR_W + ROLE_W;
    localparam int TOTAL_RAW = NUM_CORES * 2 * LEADERS_PER_POLICY;
    localparam int TOTAL     = (TOTAL_RAW > NUM_SETS / 2) ? NUM_SETS / 2 : TOTAL_RAW;
    localparam int SLOT_W    = $clog2(TOTAL + 1);
    localparam int LPP_W     = $clog2(LEADERS_PER_POLICY);
    localparam int BIM_W     = $clog2(BIMODAL_PERIOD);
    // widths for range checks on the fixed-width request fields
    localparam int SX_W      = ((SET_W > SET_INDEX_W) ? SET_W : SET_INDEX_W) + 1;
    localparam int WX_W      = ((WAY_W > WAY_INDEX_W) ? WAY_W : WAY_INDEX_W) + 1;
    localparam int CX_W      = ((CORE_W > CORE_ID_W) ? CORE_W : CORE_ID_W) + 1;
    localparam int VX_W      = (WAY_W > WAY_INDEX_W) ? WAY_W : WAY_INDEX_W;
    // conditional subtracts needed to fold a set index into range
    localparam int SET_FOLD  = ((1 << SET_INDEX_W) - 1) / NUM_SETS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_DRAW,
        ST_WAIT,
        ST_PROBE,
        ST_IDLE,
        ST_MODIFY
    } t_state;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state             r_state;
    logic [SET_W-1:0]   r_clr_addr;
    logic [SET_W-1:0]   r_cand;
    logic [DRAW_W-1:0]  r_tries;
    logic [SLOT_W-1:0]  r_slot_cnt;
    logic [LPP_W-1:0]   r_slot_lpp;
    logic               r_slot_pol;
    logic [CORE_W-1:0]  r_slot_core;
    t_req               r_op;
    logic [SET_W-1:0]   r_op_set;
    logic [SELECTOR_BITS-1:0] r_sel [NUM_CORES];
    logic [BIM_W-1:0]   r_bim;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    // ------------------------------------------------------------------
    // ram and candidate generator
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [SET_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;

    logic             lcg_start;
    logic             lcg_valid;
    logic [SET_W-1:0] lcg_cand;

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    drrip_lcg #(
        .NUM_SETS (NUM_SETS)
    ) u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lcg_start),
        .o_valid (lcg_valid),
        .o_cand  (lcg_cand)
    );

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic             req_fire;
    logic [SX_W-1:0]  set_x;
    logic [SET_W-1:0] set_mod;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;

    // set index taken modulo the set count
    always_comb begin
        set_x = SX_W'(i_req.set_index);
        for (int k = 0; k < SET_FOLD; k++) begin
            if (set_x >= SX_W'(NUM_SETS)) begin
                set_x = set_x - SX_W'(NUM_SETS);
            end
        end
        set_mod = set_x[SET_W-1:0];
    end

    // ------------------------------------------------------------------
    // row modify (data from the ram read issued at accept)
    // ------------------------------------------------------------------
    logic [1:0]         rr [NUM_WAYS];
    logic [ROLE_W-1:0]  role;
    logic               role_leader;
    logic               role_pol;
    logic [CORE_W-1:0]  role_core;
    logic               any3, any2, any1;
    logic [1:0]         top;
    logic [1:0]         age_add;
    logic [VX_W-1:0]    victim;
    logic [RR_W-1:0]    aged_rr;
    logic [RR_W-1:0]    upd_rr;
    logic [WX_W-1:0]    way_x;
    logic               way_ok;
    logic [WAY_W-1:0]   way_sel;
    logic [CX_W-1:0]    core_x;
    logic               core_ok;
    logic [CORE_W-1:0]  core_idx;
    logic [SELECTOR_BITS-1:0] sel_cur;
    logic               own_leader;
    logic               use_bim;
    logic               sel_dec;
    logic               sel_inc;
    logic [BIM_W-1:0]   n_bim;
    logic [1:0]         bim_val;
    logic [1:0]         new_val;
    logic               commit;
    logic               probe_free;
    logic [ROLE_W-1:0]  new_role;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            rr[w] = ram_rdata[2*w +: 2];
        end
        role        = ram_rdata[RR_W +: ROLE_W];
        role_leader = role[ROLE_W-1];
        role_pol    = role[ROLE_W-2];
        role_core   = role[CORE_W-1:0];

        // victim: age the set so the oldest way reads distant
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3 = any3 | (rr[w] == 2'd3);
            any2 = any2 | (rr[w] == 2'd2);
            any1 = any1 | (rr[w] == 2'd1);
        end
        if (any3) begin
            top = 2'd3;
        end else if (any2) begin
            top = 2'd2;
        end else if (any1) begin
            top = 2'd1;
        end else begin
            top = 2'd0;
        end
        age_add = RR_MAX - top;
        victim  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rr[w] == top) begin
                victim = VX_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_rr[2*w +: 2] = rr[w] + age_add;
        end

        // update: insertion policy and set dueling
        way_x    = WX_W'(r_op.way_index);
        way_ok   = (way_x < WX_W'(NUM_WAYS));
        way_sel  = way_x[WAY_W-1:0];
        core_x   = CX_W'(r_op.core_id);
        core_ok  = (core_x < CX_W'(NUM_CORES));
        core_idx = core_x[CORE_W-1:0];
        sel_cur  = r_sel[core_idx];
        own_leader = role_leader && (CX_W'(role_core) == core_x);

        n_bim   = (r_bim == BIM_W'(BIMODAL_PERIOD - 1)) ? '0 : r_bim + 1'b1;
        bim_val = (n_bim == '0) ? RR_LONG : RR_MAX;

        use_bim = 1'b0;
        sel_dec = 1'b0;
        sel_inc = 1'b0;
        priority if (r_op.is_writeback) begin
            new_val = RR_LONG;
        end else if (r_op.hit) begin
            new_val = RR_NEAR;
        end else if (!core_ok) begin
            new_val = RR_LONG;
        end else if (own_leader && (role_pol == POL_BRRIP)) begin
            sel_dec = 1'b1;
            use_bim = 1'b1;
            new_val = bim_val;
        end else if (own_leader) begin
            sel_inc = 1'b1;
            new_val = RR_LONG;
        end else if (sel_cur[SELECTOR_BITS-1]) begin
            // follower in the upper half of its range goes bimodal
            use_bim = 1'b1;
            new_val = bim_val;
        end else begin
            new_val = RR_LONG;
        end

        upd_rr = ram_rdata[RR_W-1:0];
        if (way_ok) begin
            upd_rr[2*way_sel +: 2] = new_val;
        end

        commit = (r_state == ST_MODIFY) && (!r_rsp_valid || i_rsp_ready);

        // leader build
        probe_free = !role_leader;
        new_role   = {1'b1, r_slot_pol, r_slot_core};
    end

    // ram port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_op_set;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = set_mod;
        lcg_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = {{ROLE_W{1'b0}}, {NUM_WAYS{RR_MAX}}};
            end
            ST_DRAW: begin
                lcg_start = 1'b1;
            end
            ST_WAIT: begin
                ram_re    = lcg_valid;
                ram_raddr = lcg_cand;
            end
            ST_PROBE: begin
                ram_we    = probe_free;
                ram_waddr = r_cand;
                ram_wdata = {new_role, {NUM_WAYS{RR_MAX}}};
            end
            ST_IDLE: begin
                ram_re    = req_fire;
                ram_raddr = set_mod;
            end
            ST_MODIFY: begin
                ram_we    = commit && ((r_op.action == ACT_VICTIM) || way_ok);
                ram_waddr = r_op_set;
                ram_wdata = (r_op.action == ACT_VICTIM) ? {role, aged_rr} : {role, upd_rr};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: clear sweep, leader build, request service
    // ------------------------------------------------------------------
    logic slot_last;
    assign slot_last = (r_slot_cnt == SLOT_W'(TOTAL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_tries     <= '0;
            r_slot_cnt  <= '0;
            r_slot_lpp  <= '0;
            r_slot_pol  <= POL_BRRIP;
            r_slot_core <= '0;
            r_bim       <= '0;
            r_rsp_valid <= 1'b0;
            for (int c = 0; c < NUM_CORES; c++) begin
                r_sel[c] <= '0;
            end
        end else begin
            // a new response replaces the one taken in the same cycle
            if (commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                        r_state <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (lcg_valid) begin
                        r_cand  <= lcg_cand;
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (probe_free || (r_tries == DRAW_W'(MAX_DRAWS - 1))) begin
                        // slot filled, or given up on and left empty
                        r_tries    <= '0;
                        r_slot_cnt <= r_slot_cnt + 1'b1;
                        if (r_slot_lpp == LPP_W'(LEADERS_PER_POLICY - 1)) begin
                            r_slot_lpp <= '0;
                            if (r_slot_pol == POL_SRRIP) begin
                                r_slot_pol  <= POL_BRRIP;
                                r_slot_core <= r_slot_core + 1'b1;
                            end else begin
                                r_slot_pol <= POL_SRRIP;
                            end
                        end else begin
                            r_slot_lpp <= r_slot_lpp + 1'b1;
                        end
                        r_state <= slot_last ? ST_IDLE : ST_DRAW;
                    end else begin
                        r_tries <= r_tries + 1'b1;
                        r_state <= ST_DRAW;
                    end
                end
                ST_IDLE: begin
                    if (req_fire) begin
                        r_op     <= i_req;
                        r_op_set <= set_mod;
                        r_state  <= ST_MODIFY;
                    end
                end
                ST_MODIFY: begin
                    if (commit) begin
                        if (r_op.action == ACT_VICTIM) begin
                            r_rsp.victim_valid <= 1'b1;
                            r_rsp.victim_way   <= victim[WAY_INDEX_W-1:0];
                        end else begin
                            r_rsp.victim_valid <= 1'b0;
                            r_rsp.victim_way   <= '0;
                            if (way_ok) begin
                                if (use_bim) begin
                                    r_bim <= n_bim;
                                end
                                // saturating selector moves on leader misses
                                if (sel_dec && (sel_cur != '0)) begin
                                    r_sel[core_idx] <= sel_cur - 1'b1;
                                end
                                if (sel_inc && (sel_cur != '1)) begin
                                    r_sel[core_idx] <= sel_cur + 1'b1;
                                end
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted request moves straight to its write-back cycle
    a_accept_to_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == ST_MODIFY))
        else $error("accepted request did not reach write-back");

    // a response is only produced by the write-back of a request
    a_rsp_from_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == ST_MODIFY))
        else $error("response appeared without a request");

    // row writes during service only come from the write-back cycle
    a_write_in_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ((r_state == ST_IDLE) || (r_state == ST_MODIFY)))
            |-> (r_state == ST_MODIFY))
        else $error("row written outside write-back");

    // update responses carry no victim way
    a_update_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.victim_valid) |-> (o_rsp.victim_way == '0))
        else $error("update response with nonzero way");

    // bimodal counter stays below its period
    a_bim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bim <= BIM_W'(BIMODAL_PERIOD - 1))
        else $error("bimodal counter out of range");

endmodule

// ===== rtl/drrip_ram.sv =====
// ----------------------------------------------------------------------------
// drrip_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/drrip_lcg.sv =====
// ----------------------------------------------------------------------------
// drrip_lcg
// leader set candidate generator: 36-bit lcg step and reduction mod set count
// ----------------------------------------------------------------------------
module drrip_lcg #(
    parameter int NUM_SETS = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_valid,
    output logic [$clog2(NUM_SETS)-1:0] o_cand
);

    import drrip_pkg::*;

    localparam int SET_W   = $clog2(NUM_SETS);
    // sets must be >= 512 (unchecked), so shifts up to ten cover the candidate
    localparam int MOD_TOP = CAND_W - 10;
    localparam int STEP_W  = $clog2(MOD_TOP + 1);
    localparam int SUB_W   = $clog2(NUM_SETS + 1) + MOD_TOP;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_MOD
    } t_lcg_state;

    t_lcg_state            r_state;
    logic [LCG_SEED_W-1:0] r_seed;
    logic [LCG_SEED_W-1:0] r_plo;
    logic [LCG_HALF_W-1:0] r_phi;
    logic [CAND_W-1:0]     r_rem;
    logic [STEP_W-1:0]     r_step;
    logic                  r_valid;

    logic [48:0]           prod_lo;
    logic [35:0]           prod_hi;
    logic [LCG_SEED_W-1:0] n_seed;
    logic [SUB_W-1:0]      sub;
    logic [SUB_W-1:0]      rem_x;

    // seed * mult mod 2^36 split into two narrow products
    always_comb begin
        prod_lo = r_seed[LCG_HALF_W-1:0] * LCG_MULT;
        prod_hi = r_seed[LCG_SEED_W-1:LCG_HALF_W] * LCG_MULT_LO;
        n_seed  = r_plo + {r_phi, {LCG_HALF_W{1'b0}}} + LCG_SEED_W'(LCG_INC);
        sub     = SUB_W'(NUM_SETS) << r_step;
        rem_x   = SUB_W'(r_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seed  <= LCG_SEED0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_MOD) && (r_step == '0);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_plo   <= prod_lo[LCG_SEED_W-1:0];
                        r_phi   <= prod_hi[LCG_HALF_W-1:0];
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_seed  <= n_seed;
                    r_rem   <= n_seed[CAND_LSB +: CAND_W];
                    r_step  <= STEP_W'(MOD_TOP);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // restoring reduction, one shifted subtract per cycle
                    if (rem_x >= sub) begin
                        r_rem <= r_rem - sub[CAND_W-1:0];
                    end
                    if (r_step == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_cand  = r_rem[SET_W-1:0];

endmodule
